>>> rtl/tdq_pkg.sv
// Package for the tick delay queue: field widths, function and result codes.
// No dependencies.
package tdq_pkg;
    localparam int ID_W = 8;
    localparam int TIME_W = 32;
    localparam int KIND_W = 3;
    localparam int DEF_QUEUE_DEPTH = 32;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_TIME  = 2'd1;
    localparam logic [1:0] FUNC_DELAY = 2'd2;
    localparam logic [1:0] FUNC_UNTIL = 2'd3;

    localparam logic [KIND_W-1:0] KIND_TICK_ACK = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TIME     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WAKEUP   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd3;

    typedef struct packed {
        logic              is_tick;
        logic              is_time;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] wake;
    } t_cmd;
endpackage

>>> rtl/tdq_front.sv
// Front end: accepts requests and classifies them into commands.
// Depends on tdq_pkg. The absolute wake time is resolved in the back end.
module tdq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_func,
    input  logic [tdq_pkg::ID_W-1:0]   i_task_id,
    input  logic [tdq_pkg::TIME_W-1:0] i_amount,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output tdq_pkg::t_cmd        o_cmd,
    output logic                 o_cmd_rel
);
    import tdq_pkg::*;
    logic r_full;
    t_cmd r_cmd;
    logic r_rel;

    assign o_ready = !r_full || i_cmd_ready;
    assign o_cmd_valid = r_full;
    assign o_cmd = r_cmd;
    assign o_cmd_rel = r_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_ready) begin
            r_full <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_cmd.is_tick <= (i_func == FUNC_TICK);
            r_cmd.is_time <= (i_func == FUNC_TIME);
            r_cmd.id <= i_task_id;
            r_cmd.wake <= i_amount;
            r_rel <= (i_func == FUNC_DELAY);
        end
    end
endmodule

>>> rtl/tdq_back.sv
// Back end: tick counter, sorted cell chain of waiting tasks, result sequencer.
// Depends on tdq_pkg.
module tdq_back #(
    parameter int QUEUE_DEPTH = tdq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  tdq_pkg::t_cmd        i_cmd,
    input  logic                 i_cmd_rel,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [tdq_pkg::KIND_W-1:0] o_kind,
    output logic [tdq_pkg::ID_W-1:0]   o_task_id_res,
    output logic [tdq_pkg::TIME_W-1:0] o_value,
    output logic                 o_last
);
    import tdq_pkg::*;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TIME_W-1:0] r_count;
    logic [TIME_W-1:0] r_wake [QUEUE_DEPTH];
    logic [ID_W-1:0]   r_ids  [QUEUE_DEPTH];
    logic [CW-1:0]     r_occ;
    logic              r_drain;
    logic              r_ovalid;
    logic [KIND_W-1:0] r_kind;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_value;
    logic              r_last;

    logic              out_free, head_due, start, do_pop, do_ins;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] wake, n_count;
    logic              le [QUEUE_DEPTH];
    logic              occ_ok [QUEUE_DEPTH];

    assign out_free = !r_ovalid || i_ready;
    assign head_due = (r_occ != '0) && (r_wake[0] <= r_count);
    assign o_cmd_ready = out_free && !r_drain;
    assign start = i_cmd_valid && o_cmd_ready;
    assign sum = {1'b0, r_count} + {1'b0, i_cmd.wake};
    assign wake = i_cmd_rel ? (sum[TIME_W] ? '1 : sum[TIME_W-1:0]) : i_cmd.wake;
    assign n_count = r_count + 1'b1;
    assign do_pop = r_drain && out_free && head_due;
    assign do_ins = start && !i_cmd.is_tick && !i_cmd.is_time
                    && (r_occ != CW'(QUEUE_DEPTH));

    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            occ_ok[k] = CW'(k) < r_occ;
            le[k] = occ_ok[k] && (r_wake[k] <= wake);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_ins) begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                if (!le[k]) begin
                    if (k == 0 || le[k-1]) begin
                        r_wake[k] <= wake;
                        r_ids[k] <= i_cmd.id;
                    end else begin
                        r_wake[k] <= r_wake[k-1];
                        r_ids[k] <= r_ids[k-1];
                    end
                end
            end
        end else if (do_pop) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                r_wake[k] <= r_wake[k+1];
                r_ids[k] <= r_ids[k+1];
            end
        end
    end

    logic next_due;
    assign next_due = (r_occ > CW'(1)) && (r_wake[1] <= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_occ <= '0;
            r_drain <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_free) r_ovalid <= 1'b0;
            if (do_ins) r_occ <= r_occ + 1'b1;
            if (r_drain && out_free) begin
                if (head_due) begin
                    r_ovalid <= 1'b1;
                    r_kind <= KIND_WAKEUP;
                    r_id <= r_ids[0];
                    r_value <= r_count;
                    r_last <= !next_due;
                    r_occ <= r_occ - 1'b1;
                    r_drain <= next_due;
                end else begin
                    r_drain <= 1'b0;
                end
            end
            if (start) begin
                r_id <= i_cmd.id;
                r_value <= '0;
                r_last <= 1'b1;
                if (i_cmd.is_tick) begin
                    r_count <= n_count;
                    r_ovalid <= 1'b1;
                    r_kind <= KIND_TICK_ACK;
                    r_last <= !((r_occ != '0) && (r_wake[0] <= n_count));
                    r_drain <= (r_occ != '0) && (r_wake[0] <= n_count);
                end else if (i_cmd.is_time) begin
                    r_ovalid <= 1'b1;
                    r_kind <= KIND_TIME;
                    r_value <= r_count;
                end else if (!do_ins) begin
                    r_ovalid <= 1'b1;
                    r_kind <= KIND_FULL;
                end
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_kind = r_kind;
    assign o_task_id_res = r_id;
    assign o_value = r_value;
    assign o_last = r_last;

`ifndef NO_ASSERTIONS
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH)) else $error("occupancy overflow");
    a_no_start_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> !start) else $error("command during drain");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |-> r_occ != '0) else $error("pop from empty queue");
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ > CW'(1)) |-> r_wake[0] <= r_wake[1]) else $error("queue unsorted");
`endif
endmodule

>>> rtl/tick_delay_queue_unit.sv
// Top level of the tick delay queue: front end and back end.
// Depends on tdq_pkg, tdq_front, tdq_back.
// A request passes a one-entry command stage into the back end. Time and
// full results are held in an output register; a tick gives its ack and
// then one wakeup per cycle, while the output is not stalled, from the head
// of the sorted cell chain, so a tick releasing tasks holds the back end
// until its last wakeup is given. A delay or until request inserts by a
// compare in every cell. Throughput is one item per cycle outside drains and output stalls.
module tick_delay_queue_unit #(
    parameter int QUEUE_DEPTH = tdq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_func,
    input  logic [tdq_pkg::ID_W-1:0]   i_task_id,
    input  logic [tdq_pkg::TIME_W-1:0] i_amount,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [tdq_pkg::KIND_W-1:0] o_kind,
    output logic [tdq_pkg::ID_W-1:0]   o_task_id_res,
    output logic [tdq_pkg::TIME_W-1:0] o_value,
    output logic                 o_last
);
    import tdq_pkg::*;
    logic cmd_valid, cmd_ready, cmd_rel;
    t_cmd cmd;

    tdq_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_func, .i_task_id, .i_amount,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd),
        .o_cmd_rel(cmd_rel)
    );

    tdq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_cmd(cmd), .i_cmd_rel(cmd_rel), .o_valid, .i_ready, .o_kind,
        .o_task_id_res, .o_value, .o_last
    );
endmodule

>>> tb/tick_delay_queue_unit_checker.sv
// Checker for tick_delay_queue_unit: watches both channels, predicts results, compares them.
// Depends on tdq_pkg. Hands the failure count and the number of open expectations to the top.
module tick_delay_queue_unit_checker #(
    parameter int QUEUE_DEPTH = tdq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic [1:0]                   i_func,
    input  logic [tdq_pkg::ID_W-1:0]     i_task_id,
    input  logic [tdq_pkg::TIME_W-1:0]   i_amount,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic [tdq_pkg::KIND_W-1:0]   o_kind,
    input  logic [tdq_pkg::ID_W-1:0]     o_task_id_res,
    input  logic [tdq_pkg::TIME_W-1:0]   o_value,
    input  logic                         o_last,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_wakeups,
    output int                           o_fulls
);
    timeunit 1ns;
    timeprecision 1ps;
    import tdq_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] value;
        logic              last;
    } t_result;

    t_result           expected_results[$];
    logic [TIME_W-1:0] ticks;
    logic [TIME_W-1:0] sleep_wake[QUEUE_DEPTH];
    logic [ID_W-1:0]   sleep_id[QUEUE_DEPTH];
    int                sleepers;

    assign o_pending = expected_results.size();

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    task automatic push_result(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] value, input logic last);
        t_result r;
        r.kind = kind;
        r.id = id;
        r.value = value;
        r.last = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_request(input logic [1:0] func, input logic [ID_W-1:0] id,
                                   input logic [TIME_W-1:0] amount);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] wake;
        int                n;
        int                pos;
        case (func)
            FUNC_TICK: begin
                ticks = ticks + 1'b1;
                n = 0;
                while (n < sleepers && sleep_wake[n] <= ticks) n++;
                push_result(KIND_TICK_ACK, id, '0, n == 0);
                for (int i = 0; i < n; i++) begin
                    push_result(KIND_WAKEUP, sleep_id[i], ticks, i + 1 == n);
                end
                for (int i = n; i < sleepers; i++) begin
                    sleep_wake[i - n] = sleep_wake[i];
                    sleep_id[i - n] = sleep_id[i];
                end
                sleepers -= n;
            end
            FUNC_TIME: push_result(KIND_TIME, id, ticks, 1'b1);
            default: begin
                if (func == FUNC_DELAY) begin
                    sum = {1'b0, ticks} + {1'b0, amount};
                    wake = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                end else begin
                    wake = amount;
                end
                if (sleepers >= QUEUE_DEPTH) begin
                    push_result(KIND_FULL, id, '0, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < sleepers && sleep_wake[pos] <= wake) pos++;
                    for (int i = sleepers; i > pos; i--) begin
                        sleep_wake[i] = sleep_wake[i - 1];
                        sleep_id[i] = sleep_id[i - 1];
                    end
                    sleep_wake[pos] = wake;
                    sleep_id[pos] = id;
                    sleepers++;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ticks = '0;
            sleepers = 0;
            o_fail_count = 0;
            o_wakeups = 0;
            o_fulls = 0;
            expected_results.delete();
        end else begin
            if (i_valid && o_ready) predict_request(i_func, i_task_id, i_amount);
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report($sformatf("unexpected result kind %0d id %0d", o_kind, o_task_id_res));
                end else begin
                    want = expected_results.pop_front();
                    if (o_kind == KIND_WAKEUP) o_wakeups++;
                    if (o_kind == KIND_FULL) o_fulls++;
                    if (o_kind !== want.kind)
                        report($sformatf("kind %0d, want %0d", o_kind, want.kind));
                    if (o_task_id_res !== want.id)
                        report($sformatf("task id %0d, want %0d", o_task_id_res, want.id));
                    if (o_value !== want.value)
                        report($sformatf("value %0d, want %0d", o_value, want.value));
                    if (o_last !== want.last)
                        report($sformatf("last %0b, want %0b", o_last, want.last));
                end
            end
        end
    end
endmodule

>>> tb/tick_delay_queue_unit_tb.sv
// Testbench top for tick_delay_queue_unit: clock, reset, request stimulus, receiver stalls, verdict.
// Depends on tdq_pkg, tick_delay_queue_unit and tick_delay_queue_unit_checker.
module tick_delay_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tdq_pkg::*;

    localparam int DEPTH = DEF_QUEUE_DEPTH;
    localparam int STALL_LIMIT = 3000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [1:0]          i_func = FUNC_TIME;
    logic [ID_W-1:0]     i_task_id = '0;
    logic [TIME_W-1:0]   i_amount = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [KIND_W-1:0]   o_kind;
    logic [ID_W-1:0]     o_task_id_res;
    logic [TIME_W-1:0]   o_value;
    logic                o_last;
    int                  fail_count;
    int                  pending;
    int                  wakeups;
    int                  fulls;
    int                  tx_idle_pct;
    int                  rx_idle_pct = 0;
    int                  sent;
    int                  idle_cycles;
    logic [TIME_W-1:0]   ticks_sent;

    always #10 i_clk = ~i_clk;

    tick_delay_queue_unit #(.QUEUE_DEPTH(DEPTH)) i_dut (.*);

    tick_delay_queue_unit_checker #(.QUEUE_DEPTH(DEPTH)) i_checker (
        .*, .o_fail_count(fail_count), .o_pending(pending), .o_wakeups(wakeups),
        .o_fulls(fulls)
    );

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results open", pending);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(input logic [1:0] func, input logic [ID_W-1:0] id,
                        input logic [TIME_W-1:0] amount);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_task_id <= id;
        i_amount <= amount;
        do @(posedge i_clk); while (!o_ready);
        if (func == FUNC_TICK) ticks_sent++;
        sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_request();
        int pick;
        int burst;
        pick = $urandom_range(99);
        if (pick < 6) begin
            burst = $urandom_range(DEPTH / 2, DEPTH + 3);
            repeat (burst) send(FUNC_DELAY, ID_W'($urandom), $urandom_range(0, 6));
        end else if (pick < 40) begin
            send(FUNC_TICK, ID_W'($urandom), $urandom);
        end else if (pick < 50) begin
            send(FUNC_TIME, ID_W'($urandom), $urandom);
        end else if (pick < 72) begin
            send(FUNC_DELAY, ID_W'($urandom),
                 ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 10));
        end else begin
            send(FUNC_UNTIL, ID_W'($urandom),
                 ($urandom_range(9) == 0) ? $urandom : ticks_sent + $urandom_range(0, 10) - 3);
        end
    endtask

    initial begin
        ticks_sent = '0;
        sent = 0;
        tx_idle_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(FUNC_TIME, 8'h00, '0);
        send(FUNC_TICK, 8'hFF, '1);
        send(FUNC_DELAY, 8'h01, '0);
        send(FUNC_DELAY, 8'h02, '1);
        send(FUNC_UNTIL, 8'h03, '0);
        send(FUNC_UNTIL, 8'h04, '1);
        send(FUNC_UNTIL, 8'h05, 32'd3);
        send(FUNC_DELAY, 8'h06, 32'd2);
        send(FUNC_UNTIL, 8'h07, 32'd3);
        send(FUNC_TICK, 8'h08, '0);
        send(FUNC_TICK, 8'hAA, 32'h5555_5555);
        send(FUNC_TIME, 8'h55, 32'hAAAA_AAAA);
        for (int i = 0; i < DEPTH + 1; i++) send(FUNC_UNTIL, ID_W'(i), TIME_W'(6 + (i % 3)));
        repeat (4) send(FUNC_TICK, 8'h10, '0);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 63 : 0;
            rx_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 26 : 0;
            for (int n = 0; n < 52; n++) begin
                random_request();
                if (n == 26) drain_results();
            end
        end
        repeat (DEPTH + 2) send(FUNC_TICK, ID_W'($urandom), $urandom);
        send(FUNC_DELAY, 8'hC3, '1);
        drain_results();
        repeat (40) @(posedge i_clk);

        $display("%0d requests sent, %0d ticks, %0d wakeups and %0d full replies checked",
                 sent, ticks_sent, wakeups, fulls);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
